### design/i2cm_pkg.sv
// Shared types and codes of the I2C register access master.
package i2cm_pkg;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [1:0] CFG_SLAVE_ADDRESS = 2'd0;
	localparam logic [1:0] CFG_HALF_PERIOD   = 2'd1;
	localparam logic [1:0] CFG_ACK_TIMEOUT   = 2'd2;

	localparam logic [9:0] HALF_PERIOD_RESET = 10'd2;
	localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] reg_address;
		logic [7:0] write_data;
		logic       sda_in;
	} cmd_item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       nack_error;
	} rsp_item_t;

	typedef struct packed {
		logic [1:0] index;
		logic [9:0] data;
	} cfg_write_t;

	typedef struct packed {
		logic [6:0] slave_address;
		logic [9:0] half_period_ticks;
		logic [7:0] ack_timeout_ticks;
	} cfg_t;

endpackage

### design/i2cm_chan_if.sv
// Valid/ready channel interface carrying one payload of type T.
interface i2cm_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

### design/i2cm_cfg_regs.sv
// Configuration register file of the I2C register access master.
module i2cm_cfg_regs
	import i2cm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	i2cm_chan_if.sink  cfg,
	output cfg_t       regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.slave_address     <= 7'd0;
			regs_q.half_period_ticks <= HALF_PERIOD_RESET;
			regs_q.ack_timeout_ticks <= ACK_TIMEOUT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.payload.index)
				CFG_SLAVE_ADDRESS: regs_q.slave_address     <= cfg.payload.data[6:0];
				CFG_HALF_PERIOD:   regs_q.half_period_ticks <= cfg.payload.data;
				CFG_ACK_TIMEOUT:   regs_q.ack_timeout_ticks <= cfg.payload.data[7:0];
				default: begin
				end
			endcase
		end
	end

endmodule

### design/i2cm_seq.sv
// Request register, bus sequencer and result register of the I2C master.
module i2cm_seq
	import i2cm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        regs,
	i2cm_chan_if.sink   cmd,
	i2cm_chan_if.source rsp
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_ST_HI, PH_ST_FALL, PH_RS_LOW, PH_RS_HI, PH_RS_FALL,
		PH_BIT_LOW, PH_BIT_HIGH, PH_ACK_REL, PH_ACK_WAIT,
		PH_RD_LOW, PH_RD_HIGH, PH_NACK_LOW, PH_NACK_HIGH, PH_SP_LOW, PH_SP_HIGH
	} phase_t;

	typedef enum logic [1:0] {
		BYTE_ADDR_W, BYTE_REG, BYTE_DATA, BYTE_ADDR_R
	} byte_sel_t;

	logic       valid_s1;
	cmd_item_t  item_s1;
	logic       res_valid_s2;
	rsp_item_t  res_s2;
	logic       advance;

	phase_t     phase_q, n_phase;
	byte_sel_t  byte_q, n_byte;
	logic [2:0] bit_q, n_bit;
	logic [7:0] shift_q, n_shift;
	logic [9:0] delay_q, n_delay;
	logic [7:0] ackw_q, n_ackw;
	logic       rd_q, n_rd;
	logic [7:0] reg_q, n_reg;
	logic [7:0] data_q, n_data;
	logic [7:0] rx_q, n_rx;
	logic       err_q, n_err;
	logic       scl_q, n_scl;
	logic       sda_q, n_sda;
	logic       n_done;

	logic [9:0]  hp;
	logic [10:0] dly_inc;
	logic [7:0]  shl;
	logic [7:0]  rx_shift;

	assign advance     = !res_valid_s2 || rsp.ready;
	assign cmd.ready   = !valid_s1 || advance;
	assign rsp.valid   = res_valid_s2;
	assign rsp.payload = res_s2;

	assign hp       = (regs.half_period_ticks == 10'd0) ? 10'd1 : regs.half_period_ticks;
	assign dly_inc  = {1'b0, delay_q} + 11'd1;
	assign shl      = {shift_q[6:0], 1'b0};
	assign rx_shift = {shift_q[6:0], item_s1.sda_in};

	always_comb begin
		n_phase = phase_q;
		n_byte  = byte_q;
		n_bit   = bit_q;
		n_shift = shift_q;
		n_delay = delay_q;
		n_ackw  = ackw_q;
		n_rd    = rd_q;
		n_reg   = reg_q;
		n_data  = data_q;
		n_rx    = rx_q;
		n_err   = err_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_done  = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (item_s1.kind == KIND_WRITE || item_s1.kind == KIND_READ) begin
				n_rd    = (item_s1.kind == KIND_READ);
				n_reg   = item_s1.reg_address;
				n_data  = item_s1.write_data;
				n_err   = 1'b0;
				n_bit   = 3'd0;
				n_shift = 8'd0;
				n_ackw  = 8'd0;
				n_phase = PH_ST_HI;
				n_delay = 10'd0;
			end
			n_scl = 1'b1;
			n_sda = 1'b1;
		end else if (item_s1.kind == KIND_TICK) begin
			if (phase_q == PH_ACK_WAIT) begin
				if (!item_s1.sda_in) begin
					n_delay = 10'd0;
					n_scl   = 1'b0;
					unique case (byte_q)
						BYTE_ADDR_W: begin
							n_shift = reg_q;
							n_bit   = 3'd0;
							n_byte  = BYTE_REG;
							n_phase = PH_BIT_LOW;
							n_sda   = reg_q[7];
						end
						BYTE_REG: begin
							if (rd_q) begin
								n_phase = PH_RS_LOW;
								n_sda   = 1'b1;
							end else begin
								n_shift = data_q;
								n_bit   = 3'd0;
								n_byte  = BYTE_DATA;
								n_phase = PH_BIT_LOW;
								n_sda   = data_q[7];
							end
						end
						BYTE_DATA: begin
							n_phase = PH_SP_LOW;
							n_sda   = 1'b0;
						end
						BYTE_ADDR_R: begin
							n_shift = 8'd0;
							n_bit   = 3'd0;
							n_phase = PH_RD_LOW;
							n_sda   = 1'b1;
						end
					endcase
				end else if (ackw_q >= regs.ack_timeout_ticks) begin
					n_err   = 1'b1;
					n_phase = PH_SP_LOW;
					n_scl   = 1'b0;
					n_sda   = 1'b0;
					n_delay = 10'd0;
				end else begin
					n_ackw = ackw_q + 8'd1;
				end
			end else begin
				n_delay = dly_inc[9:0];
				if (dly_inc >= {1'b0, hp}) begin
					n_delay = 10'd0;
					unique case (phase_q)
						PH_ST_HI: begin
							n_phase = PH_ST_FALL;
							n_scl   = 1'b1;
							n_sda   = 1'b0;
						end
						PH_ST_FALL: begin
							n_shift = {regs.slave_address, 1'b0};
							n_bit   = 3'd0;
							n_byte  = BYTE_ADDR_W;
							n_phase = PH_BIT_LOW;
							n_scl   = 1'b0;
							n_sda   = regs.slave_address[6];
						end
						PH_RS_LOW: begin
							n_phase = PH_RS_HI;
							n_scl   = 1'b1;
							n_sda   = 1'b1;
						end
						PH_RS_HI: begin
							n_phase = PH_RS_FALL;
							n_scl   = 1'b1;
							n_sda   = 1'b0;
						end
						PH_RS_FALL: begin
							n_shift = {regs.slave_address, 1'b1};
							n_bit   = 3'd0;
							n_byte  = BYTE_ADDR_R;
							n_phase = PH_BIT_LOW;
							n_scl   = 1'b0;
							n_sda   = regs.slave_address[6];
						end
						PH_BIT_LOW: begin
							n_phase = PH_BIT_HIGH;
							n_scl   = 1'b1;
						end
						PH_BIT_HIGH: begin
							n_scl = 1'b0;
							if (bit_q != 3'd7) begin
								n_bit   = bit_q + 3'd1;
								n_shift = shl;
								n_phase = PH_BIT_LOW;
								n_sda   = shl[7];
							end else begin
								n_phase = PH_ACK_REL;
								n_sda   = 1'b1;
							end
						end
						PH_ACK_REL: begin
							n_ackw  = 8'd0;
							n_phase = PH_ACK_WAIT;
							n_scl   = 1'b1;
							n_sda   = 1'b1;
						end
						PH_RD_LOW: begin
							n_phase = PH_RD_HIGH;
							n_scl   = 1'b1;
							n_sda   = 1'b1;
						end
						PH_RD_HIGH: begin
							n_shift = rx_shift;
							n_scl   = 1'b0;
							n_sda   = 1'b1;
							if (bit_q != 3'd7) begin
								n_bit   = bit_q + 3'd1;
								n_phase = PH_RD_LOW;
							end else begin
								n_rx    = rx_shift;
								n_phase = PH_NACK_LOW;
							end
						end
						PH_NACK_LOW: begin
							n_phase = PH_NACK_HIGH;
							n_scl   = 1'b1;
							n_sda   = 1'b1;
						end
						PH_NACK_HIGH: begin
							n_phase = PH_SP_LOW;
							n_scl   = 1'b0;
							n_sda   = 1'b0;
						end
						PH_SP_LOW: begin
							n_phase = PH_SP_HIGH;
							n_scl   = 1'b1;
							n_sda   = 1'b0;
						end
						PH_SP_HIGH: begin
							n_phase = PH_IDLE;
							n_scl   = 1'b1;
							n_sda   = 1'b1;
							n_done  = 1'b1;
						end
						default: begin
							n_phase = PH_IDLE;
							n_scl   = 1'b1;
							n_sda   = 1'b1;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			item_s1      <= '0;
			res_valid_s2 <= 1'b0;
			res_s2       <= '0;
			phase_q      <= PH_IDLE;
			byte_q       <= BYTE_ADDR_W;
			bit_q        <= 3'd0;
			shift_q      <= 8'd0;
			delay_q      <= 10'd0;
			ackw_q       <= 8'd0;
			rd_q         <= 1'b0;
			reg_q        <= 8'd0;
			data_q       <= 8'd0;
			rx_q         <= 8'd0;
			err_q        <= 1'b0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
		end else begin
			if (cmd.valid && cmd.ready) begin
				valid_s1 <= 1'b1;
				item_s1  <= cmd.payload;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_s2 <= valid_s1;
				if (valid_s1) begin
					phase_q <= n_phase;
					byte_q  <= n_byte;
					bit_q   <= n_bit;
					shift_q <= n_shift;
					delay_q <= n_delay;
					ackw_q  <= n_ackw;
					rd_q    <= n_rd;
					reg_q   <= n_reg;
					data_q  <= n_data;
					rx_q    <= n_rx;
					err_q   <= n_err;
					scl_q   <= n_scl;
					sda_q   <= n_sda;
					res_s2  <= '{scl_out:    n_scl,
					             sda_out:    n_sda,
					             busy_res:   (n_phase != PH_IDLE),
					             done_res:   n_done,
					             read_data:  n_rx,
					             nack_error: n_err};
				end
			end
		end
	end

endmodule

### design/i2c_master_register_access.sv
// Top level of the I2C register access master.
//
//   channel  role    payload
//   cmd      sink    kind, reg_address, write_data, sda_in
//   rsp      source  scl_out, sda_out, busy_res, done_res, read_data, nack_error
//   cfg      sink    index, data (register write, always ready)
//
// Every request gives exactly one result, held first in the request register and then
// in the result register. One request is taken per clock while rsp is not stalled;
// the two registers let a new request enter while a result still waits on rsp.
// A stalled rsp holds its result and backs up cmd after one further request.
// Reset releases both bus lines and returns the sequencer to idle.
module i2c_master_register_access
	import i2cm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	i2cm_chan_if.sink   cmd,
	i2cm_chan_if.source rsp,
	i2cm_chan_if.sink   cfg
);

	cfg_t regs;

	i2cm_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	i2cm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.regs   (regs),
		.cmd    (cmd),
		.rsp    (rsp)
	);

endmodule

### verif/tb_top.sv
// Self-checking testbench of the I2C register access master with a small slave model.
`timescale 1ns / 100ps

module tb_top;
	import i2cm_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int TOTAL_REQUESTS = 1450;

	typedef enum logic [3:0] {
		ST_IDLE, ST_START_HI, ST_START_FALL, ST_RS_LOW, ST_RS_HI, ST_RS_FALL,
		ST_BIT_LOW, ST_BIT_HIGH, ST_ACK_LOW, ST_ACK_WAIT, ST_RD_LOW, ST_RD_HIGH,
		ST_NACK_LOW, ST_NACK_HIGH, ST_STOP_LOW, ST_STOP_HIGH
	} bus_stage_t;

	typedef enum logic [1:0] {BYTE_DEV_WR, BYTE_REG, BYTE_DATA, BYTE_DEV_RD} frame_byte_t;

	class i2c_access_scoreboard;
		logic [6:0]  slave_addr;
		logic [9:0]  half_period;
		logic [7:0]  ack_limit;
		bus_stage_t  stage;
		frame_byte_t byte_sel;
		logic [3:0]  bit_idx;
		logic [7:0]  shifter;
		logic [9:0]  seg_ticks;
		logic [7:0]  ack_ticks;
		logic        is_read;
		logic [7:0]  reg_addr;
		logic [7:0]  wr_data;
		logic [7:0]  rx_byte;
		logic        nack;
		logic        scl;
		logic        sda;
		rsp_item_t   bus_levels_q[$];
		int          mismatches;
		int          live_items;

		function new();
			slave_addr = '0;
			half_period = HALF_PERIOD_RESET;
			ack_limit = ACK_TIMEOUT_RESET;
			stage = ST_IDLE;
			byte_sel = BYTE_DEV_WR;
			bit_idx = '0;
			shifter = '0;
			seg_ticks = '0;
			ack_ticks = '0;
			is_read = 1'b0;
			reg_addr = '0;
			wr_data = '0;
			rx_byte = '0;
			nack = 1'b0;
			scl = 1'b1;
			sda = 1'b1;
			mismatches = 0;
			live_items = 0;
		endfunction

		function void apply_setting(cfg_write_t w);
			case (w.index)
				CFG_SLAVE_ADDRESS: slave_addr = w.data[6:0];
				CFG_HALF_PERIOD:   half_period = w.data;
				CFG_ACK_TIMEOUT:   ack_limit = w.data[7:0];
				default: ;
			endcase
		endfunction

		function void go(bus_stage_t next, logic scl_v, logic sda_v);
			stage = next;
			scl = scl_v;
			sda = sda_v;
			seg_ticks = '0;
		endfunction

		function void load_byte(frame_byte_t which, logic [7:0] value);
			shifter = value;
			bit_idx = '0;
			byte_sel = which;
			go(ST_BIT_LOW, 1'b0, value[7]);
		endfunction

		function int pending();
			return bus_levels_q.size();
		endfunction

		function void note_request(cmd_item_t it);
			logic      finished;
			rsp_item_t want;
			finished = 1'b0;
			live_items++;
			if (stage == ST_IDLE) begin
				if (it.kind == KIND_WRITE || it.kind == KIND_READ) begin
					is_read = (it.kind == KIND_READ);
					reg_addr = it.reg_address;
					wr_data = it.write_data;
					nack = 1'b0;
					bit_idx = '0;
					shifter = '0;
					ack_ticks = '0;
					go(ST_START_HI, 1'b1, 1'b1);
				end else begin
					scl = 1'b1;
					sda = 1'b1;
				end
			end else if (it.kind == KIND_TICK) begin
				if (stage == ST_ACK_WAIT) begin
					if (!it.sda_in) begin
						case (byte_sel)
							BYTE_DEV_WR: load_byte(BYTE_REG, reg_addr);
							BYTE_REG: begin
								if (is_read)
									go(ST_RS_LOW, 1'b0, 1'b1);
								else
									load_byte(BYTE_DATA, wr_data);
							end
							BYTE_DATA: go(ST_STOP_LOW, 1'b0, 1'b0);
							default: begin
								shifter = '0;
								bit_idx = '0;
								go(ST_RD_LOW, 1'b0, 1'b1);
							end
						endcase
					end else if (ack_ticks >= ack_limit) begin
						nack = 1'b1;
						go(ST_STOP_LOW, 1'b0, 1'b0);
					end else begin
						ack_ticks++;
					end
				end else begin
					seg_ticks++;
					if (seg_ticks >= ((half_period == 10'd0) ? 10'd1 : half_period)) begin
						case (stage)
							ST_START_HI:   go(ST_START_FALL, 1'b1, 1'b0);
							ST_START_FALL: load_byte(BYTE_DEV_WR, {slave_addr, 1'b0});
							ST_RS_LOW:     go(ST_RS_HI, 1'b1, 1'b1);
							ST_RS_HI:      go(ST_RS_FALL, 1'b1, 1'b0);
							ST_RS_FALL:    load_byte(BYTE_DEV_RD, {slave_addr, 1'b1});
							ST_BIT_LOW:    go(ST_BIT_HIGH, 1'b1, sda);
							ST_BIT_HIGH: begin
								if (bit_idx < 4'd7) begin
									bit_idx++;
									shifter = shifter << 1;
									go(ST_BIT_LOW, 1'b0, shifter[7]);
								end else begin
									go(ST_ACK_LOW, 1'b0, 1'b1);
								end
							end
							ST_ACK_LOW: begin
								ack_ticks = '0;
								go(ST_ACK_WAIT, 1'b1, 1'b1);
							end
							ST_RD_LOW: go(ST_RD_HIGH, 1'b1, 1'b1);
							ST_RD_HIGH: begin
								shifter = {shifter[6:0], it.sda_in};
								if (bit_idx < 4'd7) begin
									bit_idx++;
									go(ST_RD_LOW, 1'b0, 1'b1);
								end else begin
									rx_byte = shifter;
									go(ST_NACK_LOW, 1'b0, 1'b1);
								end
							end
							ST_NACK_LOW:  go(ST_NACK_HIGH, 1'b1, 1'b1);
							ST_NACK_HIGH: go(ST_STOP_LOW, 1'b0, 1'b0);
							ST_STOP_LOW:  go(ST_STOP_HIGH, 1'b1, 1'b0);
							ST_STOP_HIGH: begin
								go(ST_IDLE, 1'b1, 1'b1);
								finished = 1'b1;
							end
							default: go(ST_IDLE, 1'b1, 1'b1);
						endcase
					end
				end
			end
			want.scl_out = scl;
			want.sda_out = sda;
			want.busy_res = (stage != ST_IDLE);
			want.done_res = finished;
			want.read_data = rx_byte;
			want.nack_error = nack;
			bus_levels_q.push_back(want);
		endfunction

		function void flag(string field, int want, int got);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0d, got %0d", field, want, got);
		endfunction

		function void check_result(rsp_item_t got);
			rsp_item_t want;
			if (bus_levels_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result arrived with nothing expected: %p", got);
				return;
			end
			want = bus_levels_q.pop_front();
			if (got.scl_out !== want.scl_out)
				flag("scl_out", want.scl_out, got.scl_out);
			if (got.sda_out !== want.sda_out)
				flag("sda_out", want.sda_out, got.sda_out);
			if (got.busy_res !== want.busy_res)
				flag("busy_res", want.busy_res, got.busy_res);
			if (got.done_res !== want.done_res)
				flag("done_res", want.done_res, got.done_res);
			if (got.read_data !== want.read_data)
				flag("read_data", want.read_data, got.read_data);
			if (got.nack_error !== want.nack_error)
				flag("nack_error", want.nack_error, got.nack_error);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	i2cm_chan_if #(.T(cmd_item_t))  cmd_if();
	i2cm_chan_if #(.T(rsp_item_t))  rsp_if();
	i2cm_chan_if #(.T(cfg_write_t)) cfg_if();

	i2c_master_register_access dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	i2c_access_scoreboard sb;
	bit          calm;
	logic        fail_armed;
	frame_byte_t fail_at;
	logic [7:0]  slave_reply;

	always #5 clk = ~clk;

	function automatic cmd_item_t request(logic [1:0] k, logic [7:0] r, logic [7:0] d, logic s);
		cmd_item_t it;
		it.kind = k;
		it.reg_address = r;
		it.write_data = d;
		it.sda_in = s;
		return it;
	endfunction

	// The slave acknowledges after a short random wait unless this byte is set to fail.
	function automatic logic slave_level();
		if (sb.stage == ST_ACK_WAIT) begin
			if (fail_armed && sb.byte_sel == fail_at)
				return 1'b1;
			return ($urandom_range(0, 3) == 0);
		end
		if (sb.stage == ST_RD_HIGH)
			return slave_reply[7 - sb.bit_idx];
		return 1'($urandom);
	endfunction

	task automatic push_cmd(cmd_item_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.payload <= it;
		do @(posedge clk); while (!cmd_if.ready);
		sb.note_request(it);
	endtask

	task automatic tick();
		push_cmd(request(KIND_TICK, 8'($urandom), 8'($urandom), slave_level()));
	endtask

	task automatic run_transaction(logic [1:0] k, logic [7:0] r, logic [7:0] d,
			logic [7:0] reply, logic nack_on, frame_byte_t nack_at, int noise_pct);
		fail_armed = nack_on;
		fail_at = nack_at;
		slave_reply = reply;
		push_cmd(request(k, r, d, 1'($urandom)));
		while (sb.stage != ST_IDLE) begin
			if ($urandom_range(0, 99) < noise_pct)
				push_cmd(request(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
					1'($urandom)));
			else
				tick();
		end
	endtask

	task automatic write_setting(logic [1:0] idx, logic [9:0] v);
		cfg_write_t w;
		w.index = idx;
		w.data = v;
		cfg_if.valid <= 1'b1;
		cfg_if.payload <= w;
		do @(posedge clk); while (!cfg_if.ready);
		sb.apply_setting(w);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		cmd_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(logic [6:0] addr, logic [9:0] hp, logic [7:0] limit);
		settle();
		write_setting(CFG_SLAVE_ADDRESS, {3'b000, addr});
		write_setting(CFG_HALF_PERIOD, hp);
		write_setting(CFG_ACK_TIMEOUT, {2'b00, limit});
	endtask

	task automatic random_transaction();
		run_transaction($urandom_range(0, 1) ? KIND_READ : KIND_WRITE, 8'($urandom),
			8'($urandom), 8'($urandom), $urandom_range(0, 4) == 0,
			frame_byte_t'($urandom_range(0, 3)), 3);
		repeat ($urandom_range(0, 3)) tick();
		if ($urandom_range(0, 7) == 0)
			push_cmd(request(KIND_UNUSED, 8'($urandom), 8'($urandom), 1'($urandom)));
	endtask

	initial begin
		sb = new();
		calm = 1'b0;
		fail_armed = 1'b0;
		fail_at = BYTE_DEV_WR;
		slave_reply = '0;
		arst_n <= 1'b0;
		cmd_if.valid <= 1'b0;
		cmd_if.payload <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.payload <= '0;
		rsp_if.ready <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_cmd(request(KIND_TICK, 8'hFF, 8'h00, 1'b0));
		push_cmd(request(KIND_TICK, 8'h00, 8'hFF, 1'b1));
		push_cmd(request(KIND_UNUSED, 8'hFF, 8'hFF, 1'b1));
		run_transaction(KIND_WRITE, 8'hFF, 8'h00, 8'h00, 1'b0, BYTE_DEV_WR, 0);
		run_transaction(KIND_READ, 8'h00, 8'hFF, 8'hFF, 1'b0, BYTE_DEV_WR, 0);
		run_transaction(KIND_WRITE, 8'h00, 8'hFF, 8'h00, 1'b0, BYTE_DEV_WR, 30);
		run_transaction(KIND_WRITE, 8'h81, 8'h7E, 8'h00, 1'b1, BYTE_DEV_WR, 0);
		push_cmd(request(KIND_TICK, 8'h00, 8'h00, 1'b0));

		configure(7'h7F, 10'd0, 8'd1);
		run_transaction(KIND_WRITE, 8'h3C, 8'hC3, 8'h00, 1'b1, BYTE_REG, 0);
		run_transaction(KIND_WRITE, 8'h5A, 8'hA5, 8'h00, 1'b1, BYTE_DATA, 0);
		run_transaction(KIND_READ, 8'h5A, 8'h00, 8'h00, 1'b1, BYTE_REG, 0);
		run_transaction(KIND_READ, 8'hA5, 8'h00, 8'hFF, 1'b1, BYTE_DEV_RD, 0);

		// Longest acknowledge timeout, with the device address left unacknowledged.
		configure(7'h2A, 10'd1, 8'd255);
		run_transaction(KIND_WRITE, 8'hC3, 8'h3C, 8'h00, 1'b1, BYTE_DEV_WR, 0);

		while (sb.live_items < TOTAL_REQUESTS) begin
			if ($urandom_range(0, 2) == 0) begin
				configure(7'($urandom),
					($urandom_range(0, 9) == 0) ? 10'($urandom_range(3, 5))
					: 10'($urandom_range(0, 2)),
					8'($urandom_range(1, 12)));
				calm = ($urandom_range(0, 3) == 0);
			end
			random_transaction();
		end
		calm = 1'b0;

		settle();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
			sb.check_result(rsp_if.payload);
		end
	end

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
